// File: rtl/core/bmm_pkg.sv
// Shared types and constants for the banked memory mapper.
package bmm_pkg;

  localparam int unsigned WindowBits = 11;
  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned OffWidth   = 18;
  localparam int unsigned DataWidth  = 8;

  typedef enum logic [1:0] {
    OP_MEM_READ  = 2'd0,
    OP_MEM_WRITE = 2'd1,
    OP_PORT_WRITE = 2'd2,
    OP_NOP       = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REGION_NONE   = 3'd0,
    REGION_IPL    = 3'd1,
    REGION_BASIC  = 3'd2,
    REGION_EXT    = 3'd3,
    REGION_RAM    = 3'd4,
    REGION_COMMON = 3'd5
  } region_e;

  localparam logic [7:0] PortMode    = 8'hfd;
  localparam logic [7:0] PortBank    = 8'hfe;
  localparam logic [7:0] PortDisable = 8'hff;

  localparam logic [15:0] CommonBase = 16'hf800;

  // Mapper registers as seen by the translation logic.
  typedef struct packed {
    logic [1:0] system_mode;
    logic [2:0] rom_option;
    logic [3:0] upper_bank;
    logic       mid_low_disable;
    logic       mid_high_disable;
  } mapper_cfg_t;

  typedef struct packed {
    region_e               region;
    logic [OffWidth-1:0]   offset;
    logic                  read_only;
  } xlat_t;

endpackage

// File: rtl/core/bmm_if.sv
// Valid/ready channel interfaces for mapper requests and results.
interface bmm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, output opcode, output address, output data, input ready);
  modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

interface bmm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  region;
  logic [17:0] offset;
  logic        is_write;
  logic [7:0]  write_data;

  modport source (output valid, output region, output offset, output is_write,
                  output write_data, input ready);
  modport sink   (input valid, input region, input offset, input is_write,
                  input write_data, output ready);
endinterface

// File: rtl/core/bmm_translate.sv
// Address decoder: maps a CPU address to region and offset for the current mode.
module bmm_translate (
  input  bmm_pkg::mapper_cfg_t cfg_i,
  input  logic [15:0]          addr_i,
  output bmm_pkg::xlat_t       xlat_o
);
  import bmm_pkg::*;

  logic [1:0] mo_m3;
  logic [1:0] mo_p1;
  logic [3:0] ma_p4;
  logic [3:0] ma_p2;

  // ROM options 3..6 select extension banks 0..3
  assign mo_m3 = cfg_i.rom_option[1:0] - 2'd3;
  assign mo_p1 = cfg_i.rom_option[1:0] + 2'd1;
  assign ma_p4 = cfg_i.upper_bank + 4'd4;
  assign ma_p2 = cfg_i.upper_bank + 4'd2;

  always_comb begin
    xlat_o.region    = REGION_NONE;
    xlat_o.offset    = '0;
    xlat_o.read_only = 1'b0;

    if (cfg_i.system_mode == 2'd1) begin
      if (addr_i < CommonBase) begin
        xlat_o.region = REGION_RAM;
        xlat_o.offset = {2'b00, addr_i};
      end else begin
        xlat_o.region = REGION_COMMON;
        xlat_o.offset = {{(OffWidth-WindowBits){1'b0}}, addr_i[WindowBits-1:0]};
      end
    end else if (addr_i[15:13] == 3'b000) begin
      unique case (cfg_i.system_mode)
        2'd0: begin
          xlat_o.region    = REGION_IPL;
          xlat_o.offset    = {6'd1, addr_i[11:0]};
          xlat_o.read_only = 1'b1;
        end
        2'd2: begin
          xlat_o.region    = REGION_BASIC;
          xlat_o.offset    = {2'b00, addr_i};
          xlat_o.read_only = 1'b1;
        end
        default: begin
          xlat_o.region = REGION_RAM;
          xlat_o.offset = {2'b00, addr_i};
        end
      endcase
    end else if (addr_i[15:14] == 2'b00) begin
      // Option window at 0x2000..0x3fff
      if (cfg_i.system_mode == 2'd0) begin
        xlat_o.region    = REGION_BASIC;
        xlat_o.offset    = {2'b00, addr_i};
        xlat_o.read_only = 1'b1;
      end else if (cfg_i.rom_option >= 3'd3 && cfg_i.rom_option <= 3'd6) begin
        xlat_o.region    = REGION_EXT;
        xlat_o.offset    = {3'b000, mo_m3, addr_i[12:0]};
        xlat_o.read_only = 1'b1;
      end else if (cfg_i.rom_option <= 3'd2) begin
        if (cfg_i.system_mode == 2'd2) begin
          xlat_o.region    = REGION_BASIC;
          xlat_o.offset    = {3'b000, mo_p1, addr_i[12:0]};
          xlat_o.read_only = 1'b1;
        end else if (cfg_i.rom_option == 3'd0) begin
          xlat_o.region = REGION_RAM;
          xlat_o.offset = {2'b00, addr_i};
        end else begin
          xlat_o.region = REGION_RAM;
          xlat_o.offset = {4'b0011, cfg_i.rom_option[1], addr_i[12:0]};
        end
      end
    end else if (addr_i[15:14] == 2'b01) begin
      if (!cfg_i.mid_low_disable) begin
        xlat_o.region = REGION_RAM;
        xlat_o.offset = {2'b00, addr_i};
      end
    end else if (addr_i[15:14] == 2'b10) begin
      if (!cfg_i.mid_high_disable) begin
        xlat_o.region = REGION_RAM;
        xlat_o.offset = {2'b00, addr_i};
      end
    end else begin
      // Upper bank window at 0xc000..0xffff
      if (cfg_i.upper_bank == 4'd15) begin
        if (addr_i >= CommonBase) begin
          xlat_o.region = REGION_COMMON;
          xlat_o.offset = {{(OffWidth-WindowBits){1'b0}}, addr_i[WindowBits-1:0]};
        end
      end else if (cfg_i.system_mode == 2'd3) begin
        if (cfg_i.upper_bank <= 4'd11) begin
          xlat_o.region = REGION_RAM;
          xlat_o.offset = {ma_p4, addr_i[13:0]};
        end
      end else if (cfg_i.upper_bank == 4'd0) begin
        xlat_o.region = REGION_RAM;
        xlat_o.offset = {2'b00, addr_i};
      end else if (cfg_i.upper_bank == 4'd1) begin
        xlat_o.region = REGION_RAM;
        xlat_o.offset = {4'b0000, addr_i[13:0]};
      end else if (cfg_i.system_mode == 2'd2 && cfg_i.upper_bank <= 4'd13) begin
        xlat_o.region = REGION_RAM;
        xlat_o.offset = {ma_p2, addr_i[13:0]};
      end
    end
  end

endmodule

// File: rtl/core/banked_memory_mapper.sv
// Banked memory mapper top level: mapper registers, decode and result register.
//
// Usage:
//   req_i carries one CPU transaction per beat: opcode (memory read, memory
//   write, I/O port write), 16-bit address and data byte. Port writes to
//   0xfd, 0xfe and 0xff load the mode, ROM option / upper bank and RAM
//   disable registers; they return a result with region none.
//   rsp_o returns exactly one result per request: region, 18-bit offset,
//   is_write and write_data. Reads and unmapped or ROM writes return
//   is_write low and write_data zero.
//   The decode sits between the request handshake and a single result
//   register. Throughput is one transaction per cycle; a request that
//   follows a port write already sees the new mapping.
//   When rsp_o stalls with a result held, req_i.ready drops until the
//   result is taken; otherwise a new request is taken every cycle.
//   Reset clears all mapper registers (mode zero, bank zero, RAM enabled)
//   and empties the result register.
module banked_memory_mapper (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmm_req_if.sink   req_i,
  bmm_rsp_if.source rsp_o
);
  import bmm_pkg::*;

  mapper_cfg_t cfg_q, cfg_d;
  xlat_t       xlat;

  logic        req_fire;
  logic        rsp_valid_q;
  logic [2:0]  region_q, region_d;
  logic [17:0] offset_q, offset_d;
  logic        is_write_q, is_write_d;
  logic [7:0]  wdata_q, wdata_d;

  bmm_translate u_translate (
    .cfg_i  (cfg_q),
    .addr_i (req_i.address),
    .xlat_o (xlat)
  );

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    cfg_d      = cfg_q;
    region_d   = REGION_NONE;
    offset_d   = '0;
    is_write_d = 1'b0;
    wdata_d    = '0;
    unique case (opcode_e'(req_i.opcode))
      OP_MEM_READ: begin
        region_d = xlat.region;
        offset_d = xlat.offset;
      end
      OP_MEM_WRITE: begin
        // drop writes that hit ROM or nothing
        if (xlat.region != REGION_NONE && !xlat.read_only) begin
          region_d   = xlat.region;
          offset_d   = xlat.offset;
          is_write_d = 1'b1;
          wdata_d    = req_i.data;
        end
      end
      OP_PORT_WRITE: begin
        if (req_i.address[7:0] == PortMode) begin
          cfg_d.system_mode = req_i.data[1:0];
        end else if (req_i.address[7:0] == PortBank) begin
          cfg_d.rom_option = req_i.data[2:0];
          cfg_d.upper_bank = req_i.data[7:4];
        end else if (req_i.address[7:0] == PortDisable) begin
          cfg_d.mid_low_disable  = req_i.data[0];
          cfg_d.mid_high_disable = req_i.data[1];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        cfg_q       <= cfg_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      region_q   <= region_d;
      offset_q   <= offset_d;
      is_write_q <= is_write_d;
      wdata_q    <= wdata_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.region     = region_q;
  assign rsp_o.offset     = offset_q;
  assign rsp_o.is_write   = is_write_q;
  assign rsp_o.write_data = wdata_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the banked memory mapper: directed, random, stall and back-to-back traffic.
`timescale 1ns / 1ps

module testbench;
  import bmm_pkg::*;

  // System modes as the translation uses them.
  localparam logic [1:0] ModeBoot   = 2'd0;
  localparam logic [1:0] ModeAllRam = 2'd1;
  localparam logic [1:0] ModeBasic  = 2'd2;
  localparam logic [1:0] ModeRamLow = 2'd3;
  localparam logic [3:0] BankCommon = 4'd15;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 680;

  typedef struct {
    region_e     region;
    logic [17:0] offset;
    logic        is_write;
    logic [7:0]  write_data;
  } mapped_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmm_req_if req_bus ();
  bmm_rsp_if rsp_bus ();

  banked_memory_mapper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  mapper_cfg_t mapper_regs = '0;
  mapped_t     mapped_q[$];
  int unsigned failures     = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_cycles  = 0;
  int unsigned stall_left   = 0;
  bit          idle_on      = 1'b1;

  always #5 clk_i = ~clk_i;

  initial begin
    req_bus.valid   = 1'b0;
    req_bus.opcode  = OP_NOP;
    req_bus.address = '0;
    req_bus.data    = '0;
    rsp_bus.ready   = 1'b0;
  end

  function automatic xlat_t window(region_e r, int unsigned off, logic ro);
    xlat_t w;
    w.region    = r;
    w.offset    = off[17:0];
    w.read_only = ro;
    return w;
  endfunction

  function automatic xlat_t translate_addr(logic [15:0] a);
    int unsigned mo;
    int unsigned ma;
    int unsigned low;
    logic [1:0]  mode;
    xlat_t       x;
    mo   = mapper_regs.rom_option;
    ma   = mapper_regs.upper_bank;
    mode = mapper_regs.system_mode;
    x    = window(REGION_NONE, 0, 1'b0);
    if (mode == ModeAllRam) begin
      if (a < CommonBase) x = window(REGION_RAM, a, 1'b0);
      else x = window(REGION_COMMON, a[10:0], 1'b0);
    end else if (a < 16'h2000) begin
      case (mode)
        ModeBoot:  x = window(REGION_IPL, 32'h1000 | a[11:0], 1'b1);
        ModeBasic: x = window(REGION_BASIC, a, 1'b1);
        default:   x = window(REGION_RAM, a, 1'b0);
      endcase
    end else if (a < 16'h4000) begin
      low = a[12:0];
      if (mode == ModeBoot) begin
        x = window(REGION_BASIC, a, 1'b1);
      end else if (mo >= 3 && mo <= 6) begin
        x = window(REGION_EXT, (mo - 3) * 32'h2000 + low, 1'b1);
      end else if (mo <= 2) begin
        if (mode == ModeBasic) x = window(REGION_BASIC, 32'h2000 + mo * 32'h2000 + low, 1'b1);
        else if (mo == 0) x = window(REGION_RAM, a, 1'b0);
        else x = window(REGION_RAM, 32'hc000 + (mo - 1) * 32'h2000 + low, 1'b0);
      end
    end else if (a < 16'h8000) begin
      if (!mapper_regs.mid_low_disable) x = window(REGION_RAM, a, 1'b0);
    end else if (a < 16'hc000) begin
      if (!mapper_regs.mid_high_disable) x = window(REGION_RAM, a, 1'b0);
    end else begin
      low = a[13:0];
      if (ma == BankCommon) begin
        if (a >= CommonBase) x = window(REGION_COMMON, a[10:0], 1'b0);
      end else if (mode == ModeRamLow) begin
        if (ma <= 11) x = window(REGION_RAM, 32'h10000 + ma * 32'h4000 + low, 1'b0);
      end else if (ma == 0) begin
        x = window(REGION_RAM, a, 1'b0);
      end else if (ma == 1) begin
        x = window(REGION_RAM, low, 1'b0);
      end else if (mode == ModeBasic && ma <= 13) begin
        x = window(REGION_RAM, 32'h10000 + (ma - 2) * 32'h4000 + low, 1'b0);
      end
    end
    return x;
  endfunction

  // Advance the mapper registers and return the expected result of one access.
  function automatic mapped_t map_access(opcode_e op, logic [15:0] addr, logic [7:0] data);
    xlat_t   x;
    mapped_t m;
    m.region     = REGION_NONE;
    m.offset     = '0;
    m.is_write   = 1'b0;
    m.write_data = '0;
    case (op)
      OP_MEM_READ: begin
        x        = translate_addr(addr);
        m.region = x.region;
        m.offset = x.offset;
      end
      OP_MEM_WRITE: begin
        x = translate_addr(addr);
        if (x.region != REGION_NONE && !x.read_only) begin
          m.region     = x.region;
          m.offset     = x.offset;
          m.is_write   = 1'b1;
          m.write_data = data;
        end
      end
      OP_PORT_WRITE: begin
        case (addr[7:0])
          PortMode: mapper_regs.system_mode = data[1:0];
          PortBank: begin
            mapper_regs.rom_option = data[2:0];
            mapper_regs.upper_bank = data[7:4];
          end
          PortDisable: begin
            mapper_regs.mid_low_disable  = data[0];
            mapper_regs.mid_high_disable = data[1];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_access(opcode_e op, logic [15:0] addr, logic [7:0] data);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.opcode  <= op;
    req_bus.address <= addr;
    req_bus.data    <= data;
    do @(posedge clk_i); while (!req_bus.ready);
    mapped_q.push_back(map_access(op, addr, data));
  endtask

  task automatic send_random_access();
    int unsigned roll;
    logic [15:0] addr;
    logic [7:0]  port;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      case ($urandom_range(0, 9))
        0, 1, 2: port = PortMode;
        3, 4, 5: port = PortBank;
        6, 7, 8: port = PortDisable;
        default: port = 8'($urandom);
      endcase
      send_access(OP_PORT_WRITE, {8'($urandom), port}, 8'($urandom));
    end else if (roll < 14) begin
      send_access(OP_NOP, 16'($urandom), 8'($urandom));
    end else begin
      // Bias a quarter of the addresses onto window edges.
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 11))
          0:  addr = 16'h0000;
          1:  addr = 16'h1fff;
          2:  addr = 16'h2000;
          3:  addr = 16'h3fff;
          4:  addr = 16'h4000;
          5:  addr = 16'h7fff;
          6:  addr = 16'h8000;
          7:  addr = 16'hbfff;
          8:  addr = 16'hc000;
          9:  addr = 16'hf7ff;
          10: addr = 16'hf800;
          default: addr = 16'hffff;
        endcase
      end else begin
        addr = 16'($urandom);
      end
      send_access(roll[0] ? OP_MEM_WRITE : OP_MEM_READ, addr, 8'($urandom));
    end
  endtask

  task automatic test_boot_map();
    send_access(OP_MEM_READ,  16'h0000, 8'h00);
    send_access(OP_MEM_READ,  16'h1fff, 8'hff);
    send_access(OP_MEM_WRITE, 16'h2000, 8'hff);
    send_access(OP_MEM_READ,  16'h3fff, 8'h00);
    send_access(OP_MEM_WRITE, 16'h4000, 8'h00);
    send_access(OP_MEM_WRITE, 16'hbfff, 8'ha5);
    send_access(OP_MEM_READ,  16'hc000, 8'h00);
    send_access(OP_MEM_WRITE, 16'hffff, 8'h5a);
    send_access(OP_NOP,       16'hffff, 8'hff);
  endtask

  task automatic test_port_modes();
    send_access(OP_PORT_WRITE, {8'h12, PortDisable}, 8'h03);
    send_access(OP_MEM_READ,   16'h4000, 8'h00);
    send_access(OP_MEM_WRITE,  16'h8000, 8'h11);
    send_access(OP_PORT_WRITE, 16'hfffc, 8'hff);
    send_access(OP_PORT_WRITE, {8'h00, PortMode}, 8'h01);
    send_access(OP_MEM_READ,   16'hf7ff, 8'h00);
    send_access(OP_MEM_WRITE,  16'hf800, 8'h81);
    send_access(OP_PORT_WRITE, {8'hff, PortBank}, 8'hf6);
    send_access(OP_PORT_WRITE, {8'h00, PortMode}, 8'hfe);
    send_access(OP_MEM_READ,   16'h0000, 8'h00);
    send_access(OP_MEM_READ,   16'h3fff, 8'h00);
    send_access(OP_MEM_WRITE,  16'hc000, 8'h42);
    send_access(OP_MEM_READ,   16'hffff, 8'h00);
    send_access(OP_PORT_WRITE, {8'h80, PortBank}, 8'hb7);
    send_access(OP_MEM_READ,   16'h2000, 8'h00);
    send_access(OP_PORT_WRITE, {8'h00, PortMode}, 8'h03);
    send_access(OP_MEM_WRITE,  16'hffff, 8'hc3);
    send_access(OP_PORT_WRITE, {8'h00, PortDisable}, 8'h00);
  endtask

  task automatic test_random_traffic();
    repeat (RandomItems) send_random_access();
  endtask

  // Hold the result side for a long stretch while requests keep coming.
  task automatic test_output_stall();
    hold_cycles = 120;
    repeat (40) send_random_access();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (60) send_random_access();
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      stall_left  = hold_cycles;
      hold_cycles = 0;
    end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    if (stall_left != 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mapped_t exp;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (mapped_q.size() == 0) begin
        $error("unexpected result: region %0d offset %0h", rsp_bus.region, rsp_bus.offset);
        failures++;
      end else begin
        exp = mapped_q.pop_front();
        if (rsp_bus.region !== exp.region) begin
          $error("region: expected %0d, actual %0d", exp.region, rsp_bus.region);
          failures++;
        end
        if (rsp_bus.offset !== exp.offset) begin
          $error("offset: expected %0h, actual %0h", exp.offset, rsp_bus.offset);
          failures++;
        end
        if (rsp_bus.is_write !== exp.is_write) begin
          $error("is_write: expected %0d, actual %0d", exp.is_write, rsp_bus.is_write);
          failures++;
        end
        if (rsp_bus.write_data !== exp.write_data) begin
          $error("write_data: expected %0h, actual %0h", exp.write_data, rsp_bus.write_data);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_boot_map();
    test_port_modes();
    test_random_traffic();
    test_output_stall();
    test_back_to_back();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (failures == 0 && mapped_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bmm_pkg.sv
rtl/core/bmm_if.sv
rtl/core/bmm_translate.sv
rtl/core/banked_memory_mapper.sv
tb/testbench.sv
